// File: rtl/core/stp_pkg.sv
package stp_pkg;

    // parse phases of one schedule string
    typedef enum logic [2:0] {
        PH_HOUR = 3'd0,
        PH_MIN  = 3'd1,
        PH_SEC  = 3'd2,
        PH_DAY0 = 3'd3,
        PH_DAYS = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    // parser state carried from one character to the next
    typedef struct packed {
        t_phase      phase;
        logic [6:0]  acc;
        logic [16:0] secs;
        logic [6:0]  mask;
        logic [3:0]  next_day;
        logic        range_pend;
        logic        failed;
    } t_state;

    // one result item
    typedef struct packed {
        logic        valid_res;
        logic [16:0] seconds_of_day;
        logic [6:0]  day_mask;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:      PH_HOUR,
        acc:        7'd0,
        secs:       17'd0,
        mask:       7'd0,
        next_day:   4'd0,
        range_pend: 1'b0,
        failed:     1'b0
    };

    // field limits and scale factors
    localparam logic [6:0]  HOUR_MAX     = 7'd23;
    localparam logic [6:0]  MINSEC_MAX   = 7'd59;
    localparam logic [6:0]  ACC_SAT      = 7'd99;
    localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN  = 17'd60;
    localparam logic [6:0]  ALL_DAYS     = 7'h7F;
    localparam logic [16:0] SEC_MAX      = 17'd86399;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;

endpackage

// File: rtl/core/stp_step.sv
module stp_step import stp_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_state     o_state,
    output t_result    o_result
);

    // one character of parsing: digit accumulate, field close, day list
    always_comb begin
        t_state      s;
        logic        is_dig;
        logic        day_ok;
        logic [9:0]  acc_mul;
        logic [6:0]  acc_dig;
        logic [6:0]  num;
        logic        num_bad;
        logic [16:0] add_term;
        logic [2:0]  d;
        logic [6:0]  span;

        s       = i_state;
        is_dig  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        day_ok  = (i_char >= CH_ONE) && (i_char <= CH_SEVEN);
        acc_mul = {3'd0, i_state.acc} * 10'd10 + {6'd0, i_char[3:0]};
        acc_dig = (acc_mul > {3'd0, ACC_SAT}) ? ACC_SAT : acc_mul[6:0];
        num     = is_dig ? acc_dig : i_state.acc;
        num_bad = (i_state.phase == PH_HOUR) ? (num > HOUR_MAX) : (num > MINSEC_MAX);
        d       = i_char[2:0];

        // seconds contributed by the closing number
        case (i_state.phase)
            PH_HOUR: add_term = {10'd0, num} * SEC_PER_HOUR;
            PH_MIN:  add_term = {10'd0, num} * SEC_PER_MIN;
            default: add_term = {10'd0, num};
        endcase

        // days covered by a range ending at d
        for (int k = 0; k < 7; k++) begin
            span[k] = (4'(k + 1) >= i_state.next_day) && (4'(k + 1) <= {1'b0, d});
        end

        if (!i_state.failed) begin
            case (i_state.phase)
                PH_HOUR, PH_MIN, PH_SEC: begin
                    if (is_dig) begin
                        s.acc = acc_dig;
                    end
                    if (!is_dig || i_last) begin
                        s.acc = 7'd0;
                        if (num_bad) begin
                            s.failed = 1'b1;
                        end else begin
                            s.secs = i_state.secs + add_term;
                            if (!is_dig) begin
                                if (i_char == CH_COLON && i_state.phase == PH_HOUR) begin
                                    s.phase = PH_MIN;
                                end else if (i_char == CH_COLON && i_state.phase == PH_MIN) begin
                                    s.phase = PH_SEC;
                                end else if (i_char == CH_PCT) begin
                                    s.phase = PH_DAY0;
                                end else begin
                                    s.phase = PH_DONE;
                                end
                            end
                        end
                    end
                end
                PH_DAY0, PH_DAYS: begin
                    if (i_state.phase == PH_DAY0 && i_char == CH_STAR) begin
                        s.mask  = ALL_DAYS;
                        s.phase = PH_DONE;
                    end else begin
                        s.phase = PH_DAYS;
                        if (is_dig) begin
                            if (!day_ok) begin
                                s.failed = 1'b1;
                            end else if (i_state.range_pend) begin
                                // end day must lie past the last day taken
                                if ({1'b0, d} < i_state.next_day) begin
                                    s.failed = 1'b1;
                                end else begin
                                    s.mask       = i_state.mask | span;
                                    s.range_pend = 1'b0;
                                    s.next_day   = {1'b0, d} + 4'd1;
                                end
                            end else begin
                                s.mask     = i_state.mask | (7'd1 << (d - 3'd1));
                                s.next_day = {1'b0, d} + 4'd1;
                            end
                        end else if (i_state.next_day != 4'd0 && i_char == CH_DASH) begin
                            s.range_pend = 1'b1;
                        end else begin
                            s.failed = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // result fields are zero on error
        o_result.valid_res      = !s.failed;
        o_result.seconds_of_day = s.failed ? 17'd0 : s.secs;
        o_result.day_mask       = s.failed ? 7'd0 : s.mask;

        // the last character returns the parser to its reset state
        o_state = i_last ? STATE_RESET : s;
    end

endmodule

// File: rtl/core/schedule_time_string_parser.sv
// Schedule string parser: takes one character of a string H[:M[:S]][%days] per transfer
// and gives one result per string, after the character marked last. A new character is
// taken every cycle unless the input is held; a string's result is registered when its
// last character leaves the input register. The input side keeps accepting while a
// result waits, except that the last character of the next string is held until the
// waiting result is taken. The rate of one character per cycle is set by the parser
// state update (digit accumulate, field range check and seconds add, day mask update).
module schedule_time_string_parser import stp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_valid_res,
    output logic [16:0] o_seconds_of_day,
    output logic [6:0]  o_day_mask
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out_res;
    t_result    n_out_res;
    logic       advance;

    // the held character moves on unless its result would overwrite a stalled one
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_char <= i_char_in;
            r_in_last <= i_last_char;
        end
    end

    stp_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_out_res)
    );

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_valid_res      = r_out_res.valid_res;
    assign o_seconds_of_day = r_out_res.seconds_of_day;
    assign o_day_mask       = r_out_res.day_mask;

endmodule

// File: rtl/core/stp_checker.sv
module stp_checker import stp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_valid_res,
    input logic [16:0] i_seconds_of_day,
    input logic [6:0]  i_day_mask
);

    // a failed string carries no time and no days
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_valid_res |-> i_seconds_of_day == 17'd0 && i_day_mask == 7'd0)
        else $error("failed result with nonzero fields");

    // a good string stays within one day
    a_secs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_valid_res |-> i_seconds_of_day <= SEC_MAX)
        else $error("seconds of day out of range");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_seconds_of_day) && $stable(i_day_mask)
        && $stable(i_valid_res))
        else $error("result changed while stalled");

endmodule

bind schedule_time_string_parser stp_checker u_stp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_valid),
    .i_out_ready      (i_ready),
    .i_valid_res      (o_valid_res),
    .i_seconds_of_day (o_seconds_of_day),
    .i_day_mask       (o_day_mask)
);
